FILE: src/bqwr_pkg.sv
package bqwr_pkg;

  // Default geometry
  localparam int RING_DEPTH_DEF  = 64;
  localparam int HANDLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 6;
  localparam int MARK_W  = 7;
  localparam int HOLD_W  = 8;
  localparam int COUNT_W = 7;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_HIGH_MARK = 2'd0;
  localparam logic [1:0] REG_LOW_MARK  = 2'd1;
  localparam logic [1:0] REG_HOLD_TTL  = 2'd2;

  localparam logic [MARK_W-1:0] HIGH_MARK_RST = 7'd48;
  localparam logic [MARK_W-1:0] LOW_MARK_RST  = 7'd16;
  localparam logic [HOLD_W-1:0] HOLD_TTL_RST  = 8'd0;

  // Request opcodes
  localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MARK = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLR  = 2'd3;

  // Controller to datapath command group
  typedef struct packed {
    logic             capture;
    logic             exec;
    logic             admit;
    logic             read_out;
    logic [CMD_W-1:0] op;
  } bqwr_ctl_t;

endpackage

FILE: src/buffer_queue_watermark_reclaim.sv
// Enqueue and dequeue pass the scan state, then admit or read the handle memory;
//   mark-done and clear load their result from the scan state alone.
//   A new request is taken only once the controller is back at rest (busy low).
// Results are strobed for one cycle by valid; the receiver cannot stall them.
// Synchronous reset (rst high) empties the ring, restores the registers and keeps busy high.
module buffer_queue_watermark_reclaim
  import bqwr_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Request channel
  input  logic                   start,
  output logic                   busy,
  input  logic [CMD_W-1:0]       cmd,
  input  logic [HANDLE_BITS-1:0] handle,
  input  logic [SLOT_W-1:0]      slot,
  // Result channel
  output logic                   valid,
  output logic                   dropped,
  output logic                   found,
  output logic [HANDLE_BITS-1:0] out_handle,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [COUNT_W-1:0]     pending,
  output logic                   in_overflow,
  output logic [COUNT_W-1:0]     freed_count,
  // Configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  logic [MARK_W-1:0] high_mark;
  logic [MARK_W-1:0] low_mark;
  logic [HOLD_W-1:0] hold_ttl;
  logic              cfg_write;
  logic [1:0]        reg_sel;
  bqwr_ctl_t         ctl;

  // Registers sit on word boundaries; the low address bits are ignored.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_mark <= HIGH_MARK_RST;
      low_mark  <= LOW_MARK_RST;
      hold_ttl  <= HOLD_TTL_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_HIGH_MARK: high_mark <= pwdata[MARK_W-1:0];
        REG_LOW_MARK:  low_mark  <= pwdata[MARK_W-1:0];
        REG_HOLD_TTL:  hold_ttl  <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the register; unused addresses read zero.
  always_comb begin
    unique case (reg_sel)
      REG_HIGH_MARK: prdata = PDATA_W'(high_mark);
      REG_LOW_MARK:  prdata = PDATA_W'(low_mark);
      REG_HOLD_TTL:  prdata = PDATA_W'(hold_ttl);
      default:       prdata = '0;
    endcase
  end

  // Sequence each request: scan, then admit or read for enqueue and dequeue, then strobe the result.
  bqwr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .valid (valid),
    .ctl   (ctl)
  );

  // Ring state, hold countdown cells, reclaim scan and the handle memory.
  bqwr_dpath #(
    .RING_DEPTH  (RING_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .handle      (handle),
    .slot        (slot),
    .high_mark   (high_mark),
    .low_mark    (low_mark),
    .hold_ttl    (hold_ttl),
    .dropped     (dropped),
    .found       (found),
    .out_handle  (out_handle),
    .out_slot    (out_slot),
    .pending     (pending),
    .in_overflow (in_overflow),
    .freed_count (freed_count)
  );

  // A result only leaves when the controller is back at rest.
  a_valid_idle: assert property (@(posedge clk) disable iff (rst)
    valid |-> !busy)
    else $error("result strobed while a request is in flight");

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not occupy the block");

  // A refused enqueue always leaves the overflow state set.
  a_drop_flag: assert property (@(posedge clk) disable iff (rst)
    (valid && dropped) |-> in_overflow)
    else $error("drop reported without overflow state");

  // A dequeue hit neither drops nor reclaims.
  a_found_clean: assert property (@(posedge clk) disable iff (rst)
    (valid && found) |-> (!dropped && (freed_count == '0)))
    else $error("dequeue result mixed with enqueue status");

endmodule

FILE: src/bqwr_ram.sv
module bqwr_ram
  import bqwr_pkg::*;
#(
  parameter int WIDTH = HANDLE_BITS_DEF,
  parameter int DEPTH = RING_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/bqwr_ctrl.sv
module bqwr_ctrl
  import bqwr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CMD_W-1:0] cmd,
  output logic             busy,
  output logic             valid,
  output bqwr_ctl_t        ctl
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_ADMIT = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CMD_W-1:0] op;
  logic             accept;
  logic             finish;

  assign busy   = rst || (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        case (op) inside
          CMD_ENQ: state_next = ST_ADMIT;
          CMD_DEQ: state_next = ST_READ;
          CMD_MARK, CMD_CLR: begin
            state_next = ST_IDLE;
            finish     = 1'b1;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_ADMIT, ST_READ: begin
        state_next = ST_IDLE;
        finish     = 1'b1;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= CMD_ENQ;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= finish;
      if (accept) op <= cmd;
    end
  end

  assign ctl.capture  = accept;
  assign ctl.exec     = (state == ST_EXEC);
  assign ctl.admit    = (state == ST_ADMIT);
  assign ctl.read_out = (state == ST_READ);
  assign ctl.op       = op;

endmodule

FILE: src/bqwr_dpath.sv
module bqwr_dpath
  import bqwr_pkg::*;
#(
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  bqwr_ctl_t              ctl,
  input  logic [HANDLE_BITS-1:0] handle,
  input  logic [SLOT_W-1:0]      slot,
  input  logic [MARK_W-1:0]      high_mark,
  input  logic [MARK_W-1:0]      low_mark,
  input  logic [HOLD_W-1:0]      hold_ttl,
  output logic                   dropped,
  output logic                   found,
  output logic [HANDLE_BITS-1:0] out_handle,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [COUNT_W-1:0]     pending,
  output logic                   in_overflow,
  output logic [COUNT_W-1:0]     freed_count
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > MARK_W) ? CNT_W : MARK_W;

  // (base + step) mod depth, base below depth and step at most depth
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] step);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(step);
    if (sum >= SUM_W'(RING_DEPTH)) sum = sum - SUM_W'(RING_DEPTH);
    return IDX_W'(sum);
  endfunction

  // Ring bookkeeping
  logic [IDX_W-1:0]      oldest_index;
  logic [CNT_W-1:0]      occupancy;
  logic [CNT_W-1:0]      taken_count;
  logic [CNT_W-1:0]      pending_count;
  logic                  overflow_flag;
  logic [RING_DEPTH-1:0] done;
  logic [HOLD_W-1:0]     hold_cell [RING_DEPTH];

  // Request and scan capture
  logic [HANDLE_BITS-1:0] handle_q;
  logic [SLOT_W-1:0]      slot_q;
  logic [CNT_W-1:0]       freed_q;
  logic [RING_DEPTH-1:0]  clr_mask_q;
  logic                   found_q;
  logic [IDX_W-1:0]       deq_idx_q;

  // Reclaim scan
  logic                    count_en;
  logic [RING_DEPTH-1:0]   free_vec;
  logic [2*RING_DEPTH-1:0] free_dbl;
  logic [RING_DEPTH-1:0]   free_rot;
  logic [RING_DEPTH-1:0]   stop_bit;
  logic [RING_DEPTH-1:0]   run_mask;
  logic [2*RING_DEPTH-1:0] mask_dbl;
  logic [RING_DEPTH-1:0]   clr_mask;
  logic [CNT_W-1:0]        run_idx;
  logic [CNT_W-1:0]        run_len;

  // Admission
  logic [CNT_W-1:0] occ_free;
  logic             ovf_kept;
  logic             drop;
  logic [IDX_W-1:0] tail_idx;
  logic             ram_we;

  // Dequeue and mark done
  logic [IDX_W-1:0]        deq_idx;
  logic                    deq_hit;
  logic [HANDLE_BITS-1:0]  ram_rdata;
  logic [IDX_W-1:0]        mark_idx;
  logic [SUM_W-1:0]        mark_off;
  logic                    mark_ok;

  // Enqueue: count down done entries and find the freeable run in one pass.
  // After the countdown a held entry is free when its counter was one or zero.
  assign count_en = ctl.exec && (ctl.op == CMD_ENQ) && (hold_ttl != '0);

  always_comb begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      free_vec[i] = done[i] && ((hold_ttl == '0) || (hold_cell[i] <= HOLD_W'(1)));
    end
  end

  // Rotate so the oldest entry sits at bit 0, take the trailing run of ones
  assign free_dbl = {free_vec, free_vec} >> oldest_index;
  assign free_rot = free_dbl[RING_DEPTH-1:0];
  assign stop_bit = ~free_rot & (free_rot + RING_DEPTH'(1));
  assign run_mask = free_rot & ~(free_rot + RING_DEPTH'(1));
  assign mask_dbl = {run_mask, run_mask} << oldest_index;
  assign clr_mask = mask_dbl[2*RING_DEPTH-1:RING_DEPTH];

  always_comb begin
    run_idx = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (stop_bit[i]) run_idx = run_idx | CNT_W'(i);
    end
    run_len = (&free_rot) ? CNT_W'(RING_DEPTH) : run_idx;
  end

  // Admission decision after reclaim; overflow clears before the drop check
  assign occ_free = occupancy - freed_q;
  assign ovf_kept = overflow_flag &&
                    !(CMP_W'(pending_count) < CMP_W'(low_mark));
  assign drop     = ovf_kept || (CMP_W'(pending_count) > CMP_W'(high_mark)) ||
                    (occ_free >= CNT_W'(RING_DEPTH));
  assign tail_idx = ring_add(oldest_index, occupancy);
  assign ram_we   = ctl.admit && !drop;

  // Taken entries form a prefix of the ring, so the next one to hand out
  // sits right after it
  assign deq_idx  = ring_add(oldest_index, taken_count);
  assign deq_hit  = (taken_count < occupancy);

  // Marking needs a slot inside the taken prefix
  assign mark_idx = IDX_W'(slot_q);
  assign mark_off = SUM_W'(mark_idx) - SUM_W'(oldest_index) +
                    ((mark_idx < oldest_index) ? SUM_W'(RING_DEPTH) : SUM_W'(0));
  assign mark_ok  = (32'(slot_q) < 32'(RING_DEPTH)) &&
                    (mark_off < SUM_W'(taken_count));

  bqwr_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_handle_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_idx),
    .wdata (handle_q),
    .raddr (deq_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      handle_q <= handle;
      slot_q   <= slot;
    end
    if (ctl.exec) begin
      freed_q    <= run_len;
      clr_mask_q <= clr_mask;
      found_q    <= deq_hit;
      deq_idx_q  <= deq_idx;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (count_en && done[i] && (hold_cell[i] != '0)) begin
        hold_cell[i] <= hold_cell[i] - HOLD_W'(1);
      end else if (ram_we && (tail_idx == IDX_W'(i))) begin
        hold_cell[i] <= hold_ttl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (ctl.exec && (ctl.op == CMD_CLR)) begin
      done <= '0;
    end else if (ctl.exec && (ctl.op == CMD_MARK) && mark_ok) begin
      done[mark_idx] <= 1'b1;
    end else if (ctl.admit) begin
      done <= done & ~clr_mask_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_index  <= '0;
      occupancy     <= '0;
      taken_count   <= '0;
      pending_count <= '0;
      overflow_flag <= 1'b0;
    end else if (ctl.exec && (ctl.op == CMD_CLR)) begin
      oldest_index  <= '0;
      occupancy     <= '0;
      taken_count   <= '0;
      pending_count <= '0;
      overflow_flag <= 1'b0;
    end else if (ctl.exec && (ctl.op == CMD_DEQ) && deq_hit) begin
      taken_count <= taken_count + CNT_W'(1);
      if (pending_count != '0) pending_count <= pending_count - CNT_W'(1);
    end else if (ctl.admit) begin
      oldest_index <= ring_add(oldest_index, freed_q);
      taken_count  <= taken_count - freed_q;
      if (drop) begin
        occupancy     <= occ_free;
        overflow_flag <= 1'b1;
      end else begin
        occupancy     <= occ_free + CNT_W'(1);
        pending_count <= pending_count + CNT_W'(1);
        overflow_flag <= ovf_kept;
      end
    end
  end

  // Result registers, loaded in the last cycle of each request
  always_ff @(posedge clk) begin
    if (ctl.exec && ((ctl.op == CMD_MARK) || (ctl.op == CMD_CLR))) begin
      dropped    <= 1'b0;
      found      <= 1'b0;
      out_handle <= '0;
      out_slot   <= '0;
      if (ctl.op == CMD_CLR) begin
        pending     <= '0;
        in_overflow <= 1'b0;
        freed_count <= COUNT_W'(occupancy);
      end else begin
        pending     <= COUNT_W'(pending_count);
        in_overflow <= overflow_flag;
        freed_count <= '0;
      end
    end else if (ctl.admit) begin
      dropped     <= drop;
      found       <= 1'b0;
      out_handle  <= '0;
      out_slot    <= '0;
      pending     <= drop ? COUNT_W'(pending_count) : COUNT_W'(pending_count + CNT_W'(1));
      in_overflow <= drop ? 1'b1 : ovf_kept;
      freed_count <= COUNT_W'(freed_q);
    end else if (ctl.read_out) begin
      dropped     <= 1'b0;
      found       <= found_q;
      out_handle  <= found_q ? ram_rdata : '0;
      out_slot    <= found_q ? SLOT_W'(deq_idx_q) : '0;
      pending     <= COUNT_W'(pending_count);
      in_overflow <= overflow_flag;
      freed_count <= '0;
    end
  end

endmodule

FILE: tb/sv/buffer_queue_watermark_reclaim_tb.sv
module buffer_queue_watermark_reclaim_tb;
  import bqwr_pkg::*;

  localparam int DEPTH = RING_DEPTH_DEF;
  localparam int HBITS = HANDLE_BITS_DEF;
  localparam int CYCLE_LIMIT = 300000;
  // Address 12 decodes to no register; writes there must leave the block alone.
  localparam logic [1:0] REG_RESERVED = 2'd3;

  // One request as the sender holds it; aim asks the driver to pick a slot
  // that is taken and not yet done at the moment the request goes out.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [HBITS-1:0] handle;
    logic [SLOT_W-1:0] slot;
    bit aim;
  } queue_req_t;

  // One status word as the block reports it.
  typedef struct packed {
    logic dropped;
    logic found;
    logic [HBITS-1:0] out_handle;
    logic [SLOT_W-1:0] out_slot;
    logic [COUNT_W-1:0] pending;
    logic in_overflow;
    logic [COUNT_W-1:0] freed_count;
  } queue_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] cmd = CMD_DEQ;
  logic [HBITS-1:0] handle = '0;
  logic [SLOT_W-1:0] slot = '0;
  logic valid;
  logic dropped;
  logic found;
  logic [HBITS-1:0] out_handle;
  logic [SLOT_W-1:0] out_slot;
  logic [COUNT_W-1:0] pending;
  logic in_overflow;
  logic [COUNT_W-1:0] freed_count;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  buffer_queue_watermark_reclaim DUT (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .cmd(cmd), .handle(handle), .slot(slot),
    .valid(valid), .dropped(dropped), .found(found), .out_handle(out_handle),
    .out_slot(out_slot), .pending(pending), .in_overflow(in_overflow),
    .freed_count(freed_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Shadow of the ring, advanced at each accepted request.
  logic [HBITS-1:0] ent_handle [DEPTH];
  bit ent_taken [DEPTH];
  bit ent_done [DEPTH];
  logic [HOLD_W-1:0] ent_hold [DEPTH];
  int ring_oldest = 0;
  int ring_occ = 0;
  int ring_pend = 0;
  bit ring_ovf = 1'b0;
  logic [MARK_W-1:0] cfg_high = HIGH_MARK_RST;
  logic [MARK_W-1:0] cfg_low = LOW_MARK_RST;
  logic [HOLD_W-1:0] cfg_ttl = HOLD_TTL_RST;

  queue_req_t req_backlog[$];
  queue_status_t status_due[$];
  int reqs_queued = 0;
  int reqs_accepted = 0;
  int sender_idle_pct = 0;
  bit req_taken = 1'b0;
  int mismatches = 0;
  int cycle_count = 0;
  int n_enq = 0, n_deq = 0, n_mark = 0, n_clr = 0;
  int n_drop = 0, n_found = 0, n_freed = 0;

  // Count down the hold of done entries, then free done entries from the
  // oldest end; an entry still holding blocks everything younger.
  function automatic int reclaim_done_entries();
    int freed, i, s;
    bit stop;
    freed = 0;
    stop = 1'b0;
    if (cfg_ttl != 0)
      for (i = 0; i < ring_occ; i++) begin
        s = (ring_oldest + i) % DEPTH;
        if (ent_done[s] && ent_hold[s] != 0) ent_hold[s] = ent_hold[s] - HOLD_W'(1);
      end
    while (ring_occ != 0 && !stop) begin
      s = ring_oldest;
      if (!ent_done[s] || (cfg_ttl != 0 && ent_hold[s] != 0)) begin
        stop = 1'b1;
      end else begin
        ent_done[s] = 1'b0;
        ent_taken[s] = 1'b0;
        ring_oldest = (ring_oldest + 1) % DEPTH;
        ring_occ--;
        freed++;
      end
    end
    return freed;
  endfunction

  function automatic queue_status_t advance_ring(input logic [CMD_W-1:0] c,
                                                 input logic [HBITS-1:0] h,
                                                 input logic [SLOT_W-1:0] sl);
    queue_status_t r;
    int i, s, off;
    r = '0;
    case (c)
      CMD_ENQ: begin
        r.freed_count = COUNT_W'(reclaim_done_entries());
        // Hysteresis: clear first, then drop while the flag holds.
        if (ring_ovf && ring_pend < int'(cfg_low)) ring_ovf = 1'b0;
        if (ring_ovf || ring_pend > int'(cfg_high) || ring_occ >= DEPTH) begin
          ring_ovf = 1'b1;
          r.dropped = 1'b1;
        end else begin
          s = (ring_oldest + ring_occ) % DEPTH;
          ent_handle[s] = h;
          ent_taken[s] = 1'b0;
          ent_done[s] = 1'b0;
          ent_hold[s] = cfg_ttl;
          ring_occ++;
          ring_pend++;
        end
      end
      CMD_DEQ: begin
        for (i = 0; i < ring_occ && !r.found; i++) begin
          s = (ring_oldest + i) % DEPTH;
          if (!ent_taken[s]) begin
            ent_taken[s] = 1'b1;
            if (ring_pend != 0) ring_pend--;
            r.found = 1'b1;
            r.out_handle = ent_handle[s];
            r.out_slot = SLOT_W'(s);
          end
        end
      end
      CMD_MARK: begin
        off = (int'(sl) + DEPTH - ring_oldest) % DEPTH;
        if (off < ring_occ && ent_taken[sl]) ent_done[sl] = 1'b1;
      end
      default: begin
        r.freed_count = COUNT_W'(ring_occ);
        for (i = 0; i < DEPTH; i++) begin
          ent_taken[i] = 1'b0;
          ent_done[i] = 1'b0;
        end
        ring_oldest = 0;
        ring_occ = 0;
        ring_pend = 0;
        ring_ovf = 1'b0;
      end
    endcase
    r.pending = COUNT_W'(ring_pend);
    r.in_overflow = ring_ovf;
    return r;
  endfunction

  // Pick a slot that a mark-done request would actually act on, or -1.
  function automatic int pick_taken_slot();
    int hits[$];
    int i, s;
    for (i = 0; i < ring_occ; i++) begin
      s = (ring_oldest + i) % DEPTH;
      if (ent_taken[s] && !ent_done[s]) hits.push_back(s);
    end
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(hits.size() - 1)];
  endfunction

  task automatic compare_field(input string name, input logic [HBITS-1:0] want,
                               input logic [HBITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: present the next request at the falling edge; hold it until the
  // block takes it, and idle at random between requests.
  always @(negedge clk) begin : drive_requests
    queue_req_t nxt;
    int pick;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !req_taken)) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        nxt = req_backlog.pop_front();
        if (nxt.aim) begin
          pick = pick_taken_slot();
          if (pick >= 0) nxt.slot = SLOT_W'(pick);
        end
        start <= 1'b1;
        cmd <= nxt.cmd;
        handle <= nxt.handle;
        slot <= nxt.slot;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check the strobed status against the oldest prediction, then
  // advance the shadow ring for a request taken at this edge.
  always @(posedge clk) begin : watch_results
    queue_status_t want;
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      if (valid === 1'b1) begin
        if (status_due.size() == 0) begin
          $error("status strobed with no request outstanding");
          mismatches++;
        end else begin
          want = status_due.pop_front();
          compare_field("dropped", HBITS'(want.dropped), HBITS'(dropped));
          compare_field("found", HBITS'(want.found), HBITS'(found));
          compare_field("out_handle", want.out_handle, out_handle);
          compare_field("out_slot", HBITS'(want.out_slot), HBITS'(out_slot));
          compare_field("pending", HBITS'(want.pending), HBITS'(pending));
          compare_field("in_overflow", HBITS'(want.in_overflow), HBITS'(in_overflow));
          compare_field("freed_count", HBITS'(want.freed_count), HBITS'(freed_count));
          n_drop += int'(want.dropped);
          n_found += int'(want.found);
          n_freed += int'(want.freed_count);
        end
      end
      req_taken = start && !busy;
      if (req_taken) begin
        status_due.push_back(advance_ring(cmd, handle, slot));
        reqs_accepted++;
        case (cmd)
          CMD_ENQ: n_enq++;
          CMD_DEQ: n_deq++;
          CMD_MARK: n_mark++;
          default: n_clr++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_req(input logic [CMD_W-1:0] c, input logic [HBITS-1:0] h,
                          input logic [SLOT_W-1:0] sl);
    queue_req_t r;
    r.cmd = c;
    r.handle = h;
    r.slot = sl;
    r.aim = 1'b0;
    req_backlog.push_back(r);
    reqs_queued++;
  endtask

  // Queue n random requests; whatever the three weights leave is clear-all.
  // Most mark-done requests aim at a live taken slot so entries get reclaimed.
  task automatic queue_random(input int n, input int w_enq, input int w_deq,
                              input int w_mark);
    queue_req_t r;
    int roll;
    repeat (n) begin
      roll = $urandom_range(99);
      r.handle = HBITS'($urandom());
      r.slot = SLOT_W'($urandom_range(DEPTH - 1));
      r.aim = 1'b0;
      if (roll < w_enq) begin
        r.cmd = CMD_ENQ;
      end else if (roll < w_enq + w_deq) begin
        r.cmd = CMD_DEQ;
      end else if (roll < w_enq + w_deq + w_mark) begin
        r.cmd = CMD_MARK;
        r.aim = ($urandom_range(9) < 8);
      end else begin
        r.cmd = CMD_CLR;
      end
      req_backlog.push_back(r);
      reqs_queued++;
    end
  endtask

  // Hold until every queued request is taken and every status has come back.
  task automatic wait_drained();
    while (reqs_accepted != reqs_queued || status_due.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (4) @(posedge clk);
  endtask

  // Write a register over the config port while idle, then read it back unless it is the reserved one.
  task automatic set_register(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    logic [PDATA_W-1:0] mask;
    mask = (idx == REG_HOLD_TTL) ? 32'h0000_00FF : 32'h0000_007F;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_HIGH_MARK: cfg_high = val[MARK_W-1:0];
      REG_LOW_MARK: cfg_low = val[MARK_W-1:0];
      REG_HOLD_TTL: cfg_ttl = val[HOLD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx != REG_RESERVED) begin
      @(negedge clk);
      psel <= 1'b1;
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (pready !== 1'b1);
      if ((prdata & mask) !== (val & mask)) begin
        $error("register %0d readback: expected %0h, actual %0h", idx, val & mask,
               prdata & mask);
        mismatches++;
      end
      @(negedge clk);
      psel <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  initial begin : run_test
    // Hold reset, then release it at a falling edge.
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed requests from the reset settings (48 / 16 / hold 0).
    sender_idle_pct = 30;
    push_req(CMD_DEQ, 16'h1357, 6'd0);   // dequeue on an empty ring
    push_req(CMD_MARK, 16'h0000, 6'd0);  // mark a slot that is not occupied
    push_req(CMD_ENQ, 16'h0000, 6'd63);  // slot 0, lowest handle
    push_req(CMD_ENQ, 16'hFFFF, 6'd0);   // slot 1, highest handle
    push_req(CMD_ENQ, 16'hA5A5, 6'd5);   // slot 2
    push_req(CMD_MARK, 16'hFFFF, 6'd1);  // occupied but not taken: ignored
    push_req(CMD_DEQ, 16'h0000, 6'd63);
    push_req(CMD_DEQ, 16'hFFFF, 6'd63);
    push_req(CMD_MARK, 16'h0000, 6'd1);  // done, but the oldest entry is not
    push_req(CMD_MARK, 16'h0000, 6'd1);  // marking again changes nothing
    push_req(CMD_MARK, 16'h0000, 6'd63); // beyond the occupied span
    push_req(CMD_ENQ, 16'h5A5A, 6'd0);   // nothing to free yet
    push_req(CMD_MARK, 16'hFFFF, 6'd0);
    push_req(CMD_ENQ, 16'h1234, 6'd42);  // frees the two oldest at once
    push_req(CMD_DEQ, 16'h0000, 6'd0);
    push_req(CMD_CLR, 16'hFFFF, 6'd63);  // clear with entries present
    push_req(CMD_DEQ, 16'h0000, 6'd0);
    push_req(CMD_ENQ, 16'h8001, 6'd21);
    push_req(CMD_CLR, 16'h0000, 6'd0);
    wait_drained();

    // Reserved address must not disturb the watermarks or the hold.
    set_register(REG_RESERVED, 32'hFFFF_FFFF);
    queue_random(250, 52, 25, 21);

    wait_drained();
    set_register(REG_HIGH_MARK, 32'd64);
    set_register(REG_LOW_MARK, 32'd0);
    set_register(REG_HOLD_TTL, 32'd2);
    queue_random(250, 55, 20, 21);

    wait_drained();
    sender_idle_pct = 49;
    set_register(REG_HIGH_MARK, 32'd0);
    set_register(REG_LOW_MARK, 32'd64);
    set_register(REG_HOLD_TTL, 32'd255);
    queue_random(250, 40, 30, 28);

    wait_drained();
    set_register(REG_HIGH_MARK, 32'd10);
    set_register(REG_LOW_MARK, 32'd5);
    set_register(REG_HOLD_TTL, 32'd1);
    queue_random(250, 40, 30, 28);

    wait_drained();
    sender_idle_pct = 0;
    set_register(REG_HIGH_MARK, 32'd64);
    set_register(REG_LOW_MARK, 32'd64);
    set_register(REG_HOLD_TTL, 32'd0);
    queue_random(275, 50, 22, 26);

    wait_drained();
    set_register(REG_HIGH_MARK, 32'd32);
    set_register(REG_LOW_MARK, 32'd8);
    set_register(REG_HOLD_TTL, 32'd3);
    queue_random(275, 42, 28, 28);

    wait_drained();
    repeat (8) @(posedge clk);
    if (status_due.size() != 0) begin
      $error("%0d predicted status words never arrived", status_due.size());
      mismatches++;
    end

    $display("Checked %0d requests: %0d enqueues (%0d dropped), %0d dequeues (%0d found),",
             reqs_accepted, n_enq, n_drop, n_deq, n_found);
    $display("  %0d mark-done, %0d clears, %0d entries reclaimed, over six watermark/hold settings",
             n_mark, n_clr, n_freed);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
